FILE: design/assert_macros.svh
// Concurrent assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition in one cycle implies a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) else $error(msg);

`endif

FILE: design/hclp_pkg.sv
package hclp_pkg;

  // Parse phase of the response stream.
  typedef enum logic [1:0] {
    PH_HEAD = 2'd0,
    PH_BODY = 2'd1,
    PH_DONE = 2'd2
  } phase_t;

  // Progress through a header value.
  typedef enum logic [1:0] {
    VS_BLANK = 2'd0,
    VS_SIGN  = 2'd1,
    VS_DIGIT = 2'd2,
    VS_STOP  = 2'd3
  } vstage_t;

  localparam logic [7:0] CHAR_TAB   = 8'd9;
  localparam logic [7:0] CHAR_LF    = 8'd10;
  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] CHAR_SPACE = 8'd32;
  localparam logic [7:0] CHAR_PLUS  = 8'd43;
  localparam logic [7:0] CHAR_MINUS = 8'd45;
  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_NINE  = 8'd57;
  localparam logic [7:0] CHAR_COLON = 8'd58;

  localparam logic [4:0] NAME_LEN      = 5'd14;
  localparam logic [4:0] NAME_IDX_MAX  = 5'd31;
  localparam logic [31:0] FALLBACK_RESET = 32'd999999;

  // Characters of the header name that carries the body length.
  function automatic logic [7:0] name_char(input logic [3:0] idx);
    logic [7:0] ch;
    unique case (idx)
      4'd0:    ch = "C";
      4'd1:    ch = "o";
      4'd2:    ch = "n";
      4'd3:    ch = "t";
      4'd4:    ch = "e";
      4'd5:    ch = "n";
      4'd6:    ch = "t";
      4'd7:    ch = "-";
      4'd8:    ch = "L";
      4'd9:    ch = "e";
      4'd10:   ch = "n";
      4'd11:   ch = "g";
      4'd12:   ch = "t";
      4'd13:   ch = "h";
      default: ch = 8'd0;
    endcase
    return ch;
  endfunction

endpackage

FILE: design/http_header_content_length_parser_top.sv
// Content-Length tracker for an HTTP response, one byte per beat. Each
// accepted byte gives exactly one result beat, in order; a new byte can be
// taken every cycle while results drain, and the result beat of each byte
// is presented from the result register once the byte has passed the input
// register and the update logic. A stalled result beat holds the byte in
// the input register and drops s_axis_tready until the result is taken. The
// per-byte update is a single pass through the header/body state logic,
// including the times-ten accumulate of the length digits built from two
// shifts and two adds. Assert s_axis_tuser on the first byte of a response
// to clear all parse state. Write the fallback body limit through
// cfg_we/cfg_wdata only while idle; the block itself does not enforce this.
`include "assert_macros.svh"

module http_header_content_length_parser_top #(
  parameter int LENGTH_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  // configuration: fallback_body_limit
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  // input beats
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] start_req
  // result beats
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [31:0] body_length, [63:32] body_remaining
  output logic [3:0]  m_axis_tuser,   // [1:0] phase, [2] is_body_byte, [3] length_known
  output logic        m_axis_tlast    // headers_end
);
  import hclp_pkg::*;

  localparam int W  = LENGTH_BITS;
  localparam int LW = (LENGTH_BITS > 32) ? LENGTH_BITS : 32;
  localparam logic [W-1:0] LEN_MAX = '1;

  // configuration register
  logic [31:0] fallback;

  // input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_start;

  // handshake control
  logic advance;

  // parse state
  phase_t        phase;
  logic          prev_cr, colon, line_empty, name_match;
  logic [4:0]    name_idx;
  vstage_t       vstage;
  logic          value_neg;
  logic [W-1:0]  accum;
  logic          found, len_valid;
  logic [LW-1:0] len_value, rem;

  // state after an optional start-of-response clear
  phase_t        c_phase;
  logic          c_cr, c_colon, c_empty, c_match;
  logic [4:0]    c_idx;
  vstage_t       c_vstage;
  logic          c_neg;
  logic [W-1:0]  c_accum;
  logic          c_found, c_valid;
  logic [LW-1:0] c_len, c_rem;

  // next state
  phase_t        phase_next;
  logic          prev_cr_next, colon_next, line_empty_next, name_match_next;
  logic [4:0]    name_idx_next;
  vstage_t       vstage_next;
  logic          value_neg_next;
  logic [W-1:0]  accum_next;
  logic          found_next, len_valid_next;
  logic [LW-1:0] len_value_next, rem_next;

  // per-byte flags and results
  logic          body_flag, hend_flag;
  logic [LW-1:0] blen;
  logic [LW-1:0] rem_out;
  logic          is_digit, is_blank, is_sign;
  logic [W+3:0]  accum_ten;

  // Pass a byte from the input register whenever the result slot frees up.
  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || !m_axis_tvalid || m_axis_tready;

  // Hold the fallback limit.
  always_ff @(posedge clk) begin
    if (rst) begin
      fallback <= FALLBACK_RESET;
    end else if (cfg_we) begin
      fallback <= cfg_wdata;
    end
  end

  // Capture input beats.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte  <= s_axis_tdata;
      in_start <= s_axis_tuser;
    end
  end

  // Apply the start-of-response clear.
  always_comb begin
    if (in_start) begin
      c_phase  = PH_HEAD;
      c_cr     = 1'b0;
      c_colon  = 1'b0;
      c_empty  = 1'b1;
      c_idx    = '0;
      c_match  = 1'b1;
      c_vstage = VS_BLANK;
      c_neg    = 1'b0;
      c_accum  = '0;
      c_found  = 1'b0;
      c_valid  = 1'b0;
      c_len    = '0;
      c_rem    = '0;
    end else begin
      c_phase  = phase;
      c_cr     = prev_cr;
      c_colon  = colon;
      c_empty  = line_empty;
      c_idx    = name_idx;
      c_match  = name_match;
      c_vstage = vstage;
      c_neg    = value_neg;
      c_accum  = accum;
      c_found  = found;
      c_valid  = len_valid;
      c_len    = len_value;
      c_rem    = rem;
    end
  end

  // Classify the byte and form accum * 10 + digit.
  assign is_digit  = (in_byte >= CHAR_ZERO) && (in_byte <= CHAR_NINE);
  assign is_blank  = (in_byte == CHAR_SPACE) || ((in_byte >= CHAR_TAB) && (in_byte <= CHAR_CR));
  assign is_sign   = (in_byte == CHAR_PLUS) || (in_byte == CHAR_MINUS);
  assign accum_ten = ((W+4)'(c_accum) << 3) + ((W+4)'(c_accum) << 1)
                   + (W+4)'(in_byte - CHAR_ZERO);

  // Next parse state.
  always_comb begin
    phase_next      = c_phase;
    prev_cr_next    = c_cr;
    colon_next      = c_colon;
    line_empty_next = c_empty;
    name_idx_next   = c_idx;
    name_match_next = c_match;
    vstage_next     = c_vstage;
    value_neg_next  = c_neg;
    accum_next      = c_accum;
    found_next      = c_found;
    len_valid_next  = c_valid;
    len_value_next  = c_len;
    rem_next        = c_rem;
    body_flag       = 1'b0;
    hend_flag       = 1'b0;

    unique case (c_phase)
      PH_HEAD: begin
        if (in_byte == CHAR_LF && c_cr) begin
          // end of a line
          prev_cr_next = 1'b0;
          if (c_empty) begin
            hend_flag = 1'b1;
            if (!c_valid) begin
              len_value_next = LW'(fallback);
            end
            rem_next   = len_value_next;
            phase_next = (len_value_next != '0) ? PH_BODY : PH_DONE;
          end else if (c_colon && c_match && !c_found) begin
            found_next     = 1'b1;
            len_valid_next = !(c_neg && c_accum != '0);
            len_value_next = len_valid_next ? LW'(c_accum) : '0;
          end
          colon_next      = 1'b0;
          line_empty_next = 1'b1;
          name_idx_next   = '0;
          name_match_next = 1'b1;
          vstage_next     = VS_BLANK;
          value_neg_next  = 1'b0;
          accum_next      = '0;
        end else begin
          if (c_cr || in_byte != CHAR_CR) begin
            line_empty_next = 1'b0;
          end
          prev_cr_next = (in_byte == CHAR_CR);
          if (c_colon) begin
            // value bytes
            unique case (c_vstage)
              VS_BLANK: begin
                if (!is_blank) begin
                  if (is_sign) begin
                    value_neg_next = (in_byte == CHAR_MINUS);
                    vstage_next    = VS_SIGN;
                  end else begin
                    vstage_next = is_digit ? VS_DIGIT : VS_STOP;
                  end
                end
              end
              VS_SIGN:  vstage_next = is_digit ? VS_DIGIT : VS_STOP;
              VS_DIGIT: if (!is_digit) vstage_next = VS_STOP;
              default:  vstage_next = c_vstage;
            endcase
            if (vstage_next == VS_DIGIT) begin
              accum_next = (accum_ten[W+3:W] != 4'd0) ? LEN_MAX : accum_ten[W-1:0];
            end
          end else if (in_byte == CHAR_COLON) begin
            colon_next      = 1'b1;
            name_match_next = c_match && (c_idx == NAME_LEN);
          end else begin
            // name bytes
            if (c_idx >= NAME_LEN || name_char(c_idx[3:0]) != in_byte) begin
              name_match_next = 1'b0;
            end
            if (c_idx != NAME_IDX_MAX) begin
              name_idx_next = c_idx + 5'd1;
            end
          end
        end
      end
      PH_BODY: begin
        body_flag = 1'b1;
        if (c_rem != '0) begin
          rem_next = c_rem - LW'(1);
        end
        if (rem_next == '0) begin
          phase_next = PH_DONE;
        end
      end
      default: ;
    endcase
  end

  // Result fields for this byte.
  always_comb begin
    if (phase_next == PH_HEAD) begin
      blen    = len_valid_next ? len_value_next : LW'(fallback);
      rem_out = '0;
    end else begin
      blen    = len_value_next;
      rem_out = rem_next;
    end
  end

  // Advance parse state on each byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HEAD;
      prev_cr    <= 1'b0;
      colon      <= 1'b0;
      line_empty <= 1'b1;
      name_idx   <= '0;
      name_match <= 1'b1;
      vstage     <= VS_BLANK;
      value_neg  <= 1'b0;
      accum      <= '0;
      found      <= 1'b0;
      len_valid  <= 1'b0;
      len_value  <= '0;
      rem        <= '0;
    end else if (advance) begin
      phase      <= phase_next;
      prev_cr    <= prev_cr_next;
      colon      <= colon_next;
      line_empty <= line_empty_next;
      name_idx   <= name_idx_next;
      name_match <= name_match_next;
      vstage     <= vstage_next;
      value_neg  <= value_neg_next;
      accum      <= accum_next;
      found      <= found_next;
      len_valid  <= len_valid_next;
      len_value  <= len_value_next;
      rem        <= rem_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_axis_tdata <= {rem_out[31:0], blen[31:0]};
      m_axis_tuser <= {len_valid_next, body_flag, phase_next};
      m_axis_tlast <= hend_flag;
    end
  end

  // Checks on the parse logic.
  `ASSERT_CLK(a_body_count, clk, rst, (phase == PH_BODY) |-> (rem != '0), "body with zero count")
  `ASSERT_CLK(a_valid_found, clk, rst, len_valid |-> found, "length valid without header")
  `ASSERT_CLK(a_hend_phase, clk, rst, (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tuser[1:0] != PH_HEAD), "headers end in header phase")
  `ASSERT_NEXT(a_result, clk, rst, advance, m_axis_tvalid, "byte passed without result beat")

endmodule

FILE: tb/hclp_checker.sv
`timescale 1ns / 100ps

// Watches both streams of the Content-Length parser, predicts the result of
// every accepted byte and compares the result beats in order.
module hclp_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] start_req
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [63:0] m_axis_tdata,   // [31:0] body_length, [63:32] body_remaining
  input  logic [3:0]  m_axis_tuser,   // [1:0] phase, [2] is_body_byte, [3] length_known
  input  logic        m_axis_tlast,   // headers_end
  output int          fail_count,
  output int          pending
);
  import hclp_pkg::*;

  localparam logic [8*14-1:0] LEN_HDR_NAME = "Content-Length";

  typedef struct packed {
    phase_t      phase;
    logic        body;
    logic        hend;
    logic        known;
    logic [31:0] blen;
    logic [31:0] brem;
  } byte_result_t;

  // Parser state mirrored from the block
  logic [31:0] fallback;
  phase_t      ph;
  logic        prev_cr, colon, line_empty, name_match;
  logic [4:0]  name_idx;
  vstage_t     vstage;
  logic        neg, len_found, len_valid;
  logic [31:0] accum, len_value, remaining;

  byte_result_t result_q[$];
  byte_result_t want;
  int fails  = 0;
  int queued = 0;

  assign fail_count = fails;
  assign pending    = queued;

  function automatic logic [7:0] hdr_char(input int i);
    return LEN_HDR_NAME[8*(int'(NAME_LEN) - 1 - i) +: 8];
  endfunction

  function automatic void clear_line();
    colon      = 1'b0;
    line_empty = 1'b1;
    name_idx   = '0;
    name_match = 1'b1;
    vstage     = VS_BLANK;
    neg        = 1'b0;
    accum      = '0;
  endfunction

  function automatic void clear_all();
    ph        = PH_HEAD;
    prev_cr   = 1'b0;
    clear_line();
    len_found = 1'b0;
    len_valid = 1'b0;
    len_value = '0;
    remaining = '0;
  endfunction

  // Advance the atoi-style reader of a header value by one byte
  function automatic void value_char(input logic [7:0] b);
    logic        digit;
    logic        blank;
    logic [63:0] prod;
    digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
    blank = (b == CHAR_SPACE) || ((b >= CHAR_TAB) && (b <= CHAR_CR));
    if (vstage == VS_BLANK) begin
      if (blank) return;
      if (b == CHAR_PLUS || b == CHAR_MINUS) begin
        neg    = (b == CHAR_MINUS);
        vstage = VS_SIGN;
        return;
      end
      vstage = digit ? VS_DIGIT : VS_STOP;
    end else if (vstage == VS_SIGN) begin
      vstage = digit ? VS_DIGIT : VS_STOP;
    end else if (vstage == VS_DIGIT && !digit) begin
      vstage = VS_STOP;
    end
    if (vstage == VS_DIGIT) begin
      prod = {32'd0, accum} * 64'd10 + {56'd0, b - CHAR_ZERO};
      accum = (prod > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0];
    end
  endfunction

  // One byte of the header section
  function automatic void header_char(input logic [7:0] b, output logic hend);
    hend = 1'b0;
    if (b == CHAR_LF && prev_cr) begin
      prev_cr = 1'b0;
      if (line_empty) begin
        hend = 1'b1;
        if (!len_valid) len_value = fallback;
        remaining = len_value;
        ph = (remaining != 0) ? PH_BODY : PH_DONE;
      end else if (colon && name_match && !len_found) begin
        len_found = 1'b1;
        len_valid = !(neg && accum != 0);
        len_value = len_valid ? accum : '0;
      end
      clear_line();
      return;
    end
    if (prev_cr || b != CHAR_CR) line_empty = 1'b0;
    prev_cr = (b == CHAR_CR);
    if (colon) begin
      value_char(b);
    end else if (b == CHAR_COLON) begin
      colon      = 1'b1;
      name_match = name_match && (name_idx == NAME_LEN);
    end else begin
      if (name_idx >= NAME_LEN || hdr_char(int'(name_idx)) != b) name_match = 1'b0;
      if (name_idx < NAME_IDX_MAX) name_idx = name_idx + 5'd1;
    end
  endfunction

  // Expected result of one accepted byte
  function automatic byte_result_t track_byte(input logic [7:0] b, input logic st);
    byte_result_t r;
    logic         hend;
    hend   = 1'b0;
    r.body = 1'b0;
    if (st) clear_all();
    if (ph == PH_HEAD) begin
      header_char(b, hend);
    end else if (ph == PH_BODY) begin
      r.body = 1'b1;
      if (remaining != 0) remaining = remaining - 32'd1;
      if (remaining == 0) ph = PH_DONE;
    end
    r.phase = ph;
    r.hend  = hend;
    r.known = len_valid;
    r.blen  = (ph == PH_HEAD) ? (len_valid ? len_value : fallback) : len_value;
    r.brem  = (ph == PH_HEAD) ? 32'd0 : remaining;
    return r;
  endfunction

  task automatic check_field(input string fname, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s mismatch: expected %0d, actual %0d", fname, want_v, got_v);
      fails++;
    end
  endtask

  // Predict on input beats, compare on result beats
  always @(posedge clk) begin
    if (rst) begin
      fallback = FALLBACK_RESET;
      clear_all();
      result_q.delete();
      queued <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (result_q.size() == 0) begin
          $error("result beat with no byte waiting for it");
          fails++;
        end else begin
          want = result_q.pop_front();
          check_field("phase", 32'(want.phase), 32'(m_axis_tuser[1:0]));
          check_field("is_body_byte", 32'(want.body), 32'(m_axis_tuser[2]));
          check_field("headers_end", 32'(want.hend), 32'(m_axis_tlast));
          check_field("length_known", 32'(want.known), 32'(m_axis_tuser[3]));
          check_field("body_length", want.blen, m_axis_tdata[31:0]);
          check_field("body_remaining", want.brem, m_axis_tdata[63:32]);
        end
      end
      if (cfg_we) fallback = cfg_wdata;
      if (s_axis_tvalid && s_axis_tready)
        result_q.push_back(track_byte(s_axis_tdata, s_axis_tuser));
      queued <= result_q.size();
    end
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps

// Feeds HTTP responses byte by byte into the Content-Length parser under
// several fallback limits, with random stalls on both streams.
module tb;
  import hclp_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
  } stim_beat_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [31:0] cfg_wdata;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] data_byte
  logic        s_axis_tuser;   // [0] start_req
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;   // [31:0] body_length, [63:32] body_remaining
  logic [3:0]  m_axis_tuser;   // [1:0] phase, [2] is_body_byte, [3] length_known
  logic        m_axis_tlast;   // headers_end

  int fail_count;
  int pending;
  logic idle_on;
  int bytes_sent;
  int responses;
  int settings_used;
  stim_beat_t byte_q[$];

  http_header_content_length_parser_top uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  hclp_checker chk (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop for a hung run
  initial begin
    #2_000_000;
    $display("run timed out with %0d results outstanding", pending);
    $display("*** FAILED ***");
    $finish;
  end

  // Stall the result stream about one cycle in five while idle_on is set
  always @(posedge clk) begin
    m_axis_tready <= idle_on ? ($urandom_range(99) >= 20) : 1'b1;
  end

  function automatic void push_byte(input logic [7:0] b, input logic st);
    stim_beat_t nb;
    nb.data  = b;
    nb.start = st;
    byte_q.push_back(nb);
  endfunction

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], 1'b0);
  endfunction

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 5))
      0:       return CHAR_SPACE;
      1:       return CHAR_TAB;
      2:       return CHAR_LF;
      3:       return 8'd11;
      4:       return 8'd12;
      default: return CHAR_CR;
    endcase
  endfunction

  // Header value: blanks, optional sign, optional digits, optional junk
  function automatic void push_value();
    int sel;
    repeat ($urandom_range(0, 2)) push_byte(pick_blank(), 1'b0);
    sel = $urandom_range(0, 9);
    if (sel < 2) push_byte(CHAR_PLUS, 1'b0);
    else if (sel < 4) push_byte(CHAR_MINUS, 1'b0);
    sel = $urandom_range(0, 19);
    if (sel < 2) begin
      // no digits at all
    end else if (sel < 15) begin
      push_byte(CHAR_ZERO + 8'($urandom_range(0, 9)), 1'b0);
    end else if (sel < 17) begin
      repeat (2) push_byte(CHAR_ZERO + 8'($urandom_range(0, 9)), 1'b0);
    end else if (sel == 17) begin
      push_text("4294967295");
    end else if (sel == 18) begin
      push_text("4294967296");
    end else begin
      repeat ($urandom_range(10, 13)) push_byte(CHAR_ZERO + 8'($urandom_range(0, 9)), 1'b0);
    end
    if ($urandom_range(0, 4) == 0) push_byte(8'($urandom_range(0, 255)), 1'b0);
  endfunction

  // One header line of a random kind, ending in CR LF
  function automatic void push_header_line();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 40) begin
      push_text("Content-Length:");
      push_value();
    end else if (sel < 48) begin
      push_text("Content-Length");
      if ($urandom_range(0, 1)) push_text(" 7");
    end else if (sel < 58) begin
      case ($urandom_range(0, 3))
        0:       push_text("content-length:");
        1:       push_text("Content-Lengt:");
        2:       push_text("Content-Lengthh:");
        default: push_text("Content-Length :");
      endcase
      push_value();
    end else if (sel < 70) begin
      push_text("X-Id:");
      repeat ($urandom_range(0, 6)) push_byte(8'($urandom_range(33, 126)), 1'b0);
    end else if (sel < 80) begin
      repeat ($urandom_range(30, 40)) push_byte(8'($urandom_range(97, 122)), 1'b0);
      push_text(":3");
    end else if (sel < 90) begin
      // bare CR and bare LF inside a line
      repeat ($urandom_range(2, 8)) begin
        case ($urandom_range(0, 3))
          0:       push_byte(8'd97, 1'b0);
          1:       push_byte(CHAR_CR, 1'b0);
          2:       push_byte(CHAR_LF, 1'b0);
          default: push_byte(CHAR_COLON, 1'b0);
        endcase
      end
    end else begin
      repeat ($urandom_range(1, 8)) push_byte(8'($urandom_range(0, 255)), 1'b0);
    end
    push_text("\r\n");
  endfunction

  // Queue one response; its first byte carries start_req
  function automatic void push_response();
    int first;
    first = byte_q.size();
    if ($urandom_range(0, 99) < 85) begin
      if ($urandom_range(0, 9) < 3) push_text("HTTP/1.1 200 OK\r\n");
      repeat ($urandom_range(0, 4)) push_header_line();
      push_text("\r\n");
      repeat ($urandom_range(0, 24)) push_byte(8'($urandom_range(0, 255)), 1'b0);
    end else begin
      // noise, with start_req now and then
      repeat ($urandom_range(4, 30))
        push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 19) == 0);
    end
    byte_q[first].start = 1'b1;
    responses++;
  endfunction

  // Present one byte, hold until it is taken, then maybe idle before the next
  task automatic send_byte(input stim_beat_t beat);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= beat.data;
    s_axis_tuser  <= beat.start;
    do @(posedge clk); while (!s_axis_tready);
    bytes_sent++;
    if (idle_on && $urandom_range(99) < 25) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain_queue();
    while (byte_q.size() != 0) send_byte(byte_q.pop_front());
    s_axis_tvalid <= 1'b0;
    // wait for every result to be checked, then idle before going on
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_fallback(input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    settings_used++;
  endtask

  initial begin
    logic [31:0] limit;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    idle_on       = 1'b1;
    bytes_sent    = 0;
    responses     = 0;
    settings_used = 1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: byte extremes, a zero length body, a byte after completion
    push_byte(8'hFF, 1'b1);
    push_byte(8'h00, 1'b0);
    push_text("\r\n");
    push_text("Content-Length:0\r\n\r\n");
    push_byte(8'h41, 1'b0);
    drain_queue();

    // Random responses under a range of fallback limits
    for (int setting = 0; setting < 7; setting++) begin
      idle_on <= (setting != 2);
      case (setting)
        0:       limit = 32'd3;
        1:       limit = 32'd0;
        2:       limit = 32'hFFFF_FFFF;
        3:       limit = 32'($urandom_range(1, 12));
        4:       limit = 32'd1;
        5:       limit = $urandom;
        default: limit = 32'($urandom_range(0, 20));
      endcase
      write_fallback(limit);
      while (byte_q.size() < 150) push_response();
      drain_queue();
    end

    repeat (8) @(posedge clk);
    $display("Sent %0d bytes in %0d responses under %0d fallback limits,",
             bytes_sent, responses, settings_used);
    $display("with random stalls on both streams and one stall-free stretch.");
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
